>>> sv/gmep_pkg.sv
`timescale 1ns / 1ps

package gmep_pkg;

    // Input request: pixel or flush tick
    typedef struct packed {
        logic       mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in;

    // Result request
    typedef struct packed {
        logic edge_res;
        logic frame_end;
    } t_out;

    // Per-item control that travels down the pipe
    typedef struct packed {
        logic interior;  // smoothed value is kept (if green test passes)
        logic s0;        // mask line bank that holds row gr-2
        logic res;       // item produces a result
        logic zero;      // result on row 0 or column 0
        logic rzero;     // right column of the gradient window is outside the frame
        logic last;      // last result of the frame
    } t_tag;

    localparam int unsigned CH_BITS  = 8;
    localparam int unsigned PIX_BITS = 3 * CH_BITS;
    localparam int unsigned ROW_BITS = 13;   // row runs to height+3 while draining

    localparam logic [11:0] MIN_SIDE   = 12'd5;
    localparam logic [11:0] MAX_HEIGHT = 12'd4095;

    localparam logic [11:0] RST_WIDTH     = 12'd640;
    localparam logic [11:0] RST_HEIGHT    = 12'd480;
    localparam logic [7:0]  RST_MARGIN    = 8'd10;
    localparam logic [10:0] RST_THRESHOLD = 11'd30;

    localparam logic [7:0] CFG_WIDTH     = 8'd0;
    localparam logic [7:0] CFG_HEIGHT    = 8'd1;
    localparam logic [7:0] CFG_MARGIN    = 8'd2;
    localparam logic [7:0] CFG_THRESHOLD = 8'd3;

    // floor(s / 273) == (s * DIV_K) >> DIV_SHIFT for every s below 273 * 256
    localparam logic [16:0] DIV_K     = 17'd122911;
    localparam int unsigned DIV_SHIFT = 25;

    localparam logic [5:0] GAUSS_WT [5][5] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

endpackage

>>> sv/green_mask_edge_pipeline.sv
`timescale 1ns / 1ps
// Channel  | Signals                                   | Moves
// ---------+-------------------------------------------+------------------------------
// in       | i_in_valid, o_in_ready, i_in_data         | pixel or flush request
// out      | o_out_valid, i_out_ready, o_out_data      | edge result request
// cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index/data| register write request
//
// One request per cycle while no result is stalled. A result becomes valid once the
// request causing it has passed pipe stages 1 through 8 and the result register.
// Reset (synchronous, active low) clears position counters, windows, valid bits
// and loads the register defaults. A stalled result stalls the whole pipe;
// o_in_ready is high whenever the result register is empty or being taken.

module green_mask_edge_pipeline
    import gmep_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned NST = 9;

    // configuration
    logic [11:0] r_fw, r_fh;
    logic [7:0]  r_margin;
    logic [10:0] r_thr;
    logic [21:0] r_t2;
    logic [WW-1:0] eff_w;
    logic [11:0]   eff_h;

    // stream position
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [CW-1:0]       r_col, n_col;

    // pipe control
    logic           adv, acc, step, draining;
    logic [NST-1:0] r_vld;
    t_tag           r_tag [NST];
    t_tag           tag_new;
    logic [CW-1:0]  r_gc [5];
    logic [CW-1:0]  gc_new;

    // stage data
    logic [PIX_BITS-1:0] pix, r_pix0;
    logic [1:0]          r_bank0;
    logic [PIX_BITS-1:0] r_pix_q [4];
    logic [PIX_BITS-1:0] r_swin [5][5];
    logic [14:0]         r_rsum [3][5];
    logic [16:0]         r_sum [3];
    logic [7:0]          r_v [3];
    logic [PIX_BITS-1:0] kept, r_kept;
    logic [PIX_BITS-1:0] r_mq [2];
    logic [PIX_BITS-1:0] r_gwin [3][3];
    logic signed [10:0]  r_gx [3], r_gy [3];
    logic [19:0]         r_gx2 [3], r_gy2 [3];
    t_out                r_out;
    logic                r_out_vld;

    always_comb begin
        if (r_fw < MIN_SIDE) begin
            eff_w = WW'(MIN_SIDE);
        end else if (13'(r_fw) > 13'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_fw);
        end
        if (r_fh < MIN_SIDE) begin
            eff_h = MIN_SIDE;
        end else begin
            eff_h = (r_fh > MAX_HEIGHT) ? MAX_HEIGHT : r_fh;
        end
    end

    // advance everything together unless a result is held
    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Decode the request against the stream position. A flush before the last
    // pixel is dropped; a pixel after it counts as a flush.
    always_comb begin
        draining = r_row >= ROW_BITS'(eff_h);
        acc      = i_in_valid && adv;
        step     = acc && (draining || !i_in_data.mode);
        pix      = draining ? '0 : {i_in_data.red, i_in_data.green, i_in_data.blue};

        tag_new.interior = (r_row >= ROW_BITS'(4)) && !draining && (r_col >= CW'(4));
        if (r_col >= CW'(2)) begin
            gc_new     = r_col - CW'(2);
            tag_new.s0 = r_row[0];
        end else begin
            gc_new     = CW'(WW'(r_col) + eff_w - WW'(2));
            tag_new.s0 = ~r_row[0];
        end
        if (r_col >= CW'(3)) begin
            tag_new.res  = r_row >= ROW_BITS'(3);
            tag_new.zero = (r_row == ROW_BITS'(3)) || (r_col == CW'(3));
        end else begin
            tag_new.res  = r_row >= ROW_BITS'(4);
            tag_new.zero = r_row == ROW_BITS'(4);
        end
        tag_new.rzero = r_col == CW'(2);
        tag_new.last  = (r_row == ROW_BITS'(eff_h) + ROW_BITS'(3)) && (r_col == CW'(2));

        n_row = r_row;
        n_col = r_col;
        if (tag_new.last) begin
            n_row = '0;
            n_col = '0;
        end else if (WW'(r_col) == eff_w - WW'(1)) begin
            n_row = r_row + ROW_BITS'(1);
            n_col = '0;
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // configuration writes and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= RST_WIDTH;
            r_fh     <= RST_HEIGHT;
            r_margin <= RST_MARGIN;
            r_thr    <= RST_THRESHOLD;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            if (step) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH: begin
                        r_fw  <= i_cfg_data;
                        r_row <= '0;
                        r_col <= '0;
                    end
                    CFG_HEIGHT: begin
                        r_fh  <= i_cfg_data;
                        r_row <= '0;
                        r_col <= '0;
                    end
                    CFG_MARGIN: begin
                        r_margin <= i_cfg_data[7:0];
                        r_row    <= '0;
                        r_col    <= '0;
                    end
                    CFG_THRESHOLD: begin
                        r_thr <= i_cfg_data[10:0];
                        r_row <= '0;
                        r_col <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // threshold squared; the user must keep config static while items are in flight (not enforced here)
    always_ff @(posedge i_clk) begin
        r_t2 <= 22'(r_thr) * 22'(r_thr);
    end

    // pixel line store: four row banks, read-first so the bank being written
    // still returns row r-4
    for (genvar b = 0; b < 4; b++) begin : g_pix
        logic [PIX_BITS-1:0] r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (step) begin
                r_pix_q[b] <= r_mem[r_col];
                if (r_row[1:0] == 2'(b)) begin
                    r_mem[r_col] <= pix;
                end
            end
        end
    end

    // mask line store: two row banks at column gc, written with the kept pixel
    for (genvar b = 0; b < 2; b++) begin : g_mask
        logic [PIX_BITS-1:0] r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (adv && r_vld[4]) begin
                r_mq[b] <= r_mem[r_gc[4]];
                if (r_tag[4].s0 == 1'(b)) begin
                    r_mem[r_gc[4]] <= kept;
                end
            end
        end
    end

    // valid bits and tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[NST-2:0], step};
            r_out_vld <= r_vld[NST-1] && r_tag[NST-1].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[0] <= tag_new;
            r_gc[0]  <= gc_new;
            r_pix0   <= pix;
            r_bank0  <= r_row[1:0];
            for (int k = 1; k < NST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_gc[k] <= r_gc[k-1];
            end
        end
    end

    // smoothing window: shift in column c of rows r-4..r
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 5; j++) begin
                    r_swin[i][j] <= '0;
                end
            end
        end else if (adv && r_vld[0]) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_swin[i][j] <= r_swin[i][j+1];
                end
            end
            for (int i = 0; i < 4; i++) begin
                r_swin[i][4] <= r_pix_q[2'(r_bank0 + 2'(i))];
            end
            r_swin[4][4] <= r_pix0;
        end
    end

    // Gaussian: weighted row sums, then total, then divide by 273
    always_ff @(posedge i_clk) begin
        logic [14:0] acc_row;
        logic [16:0] acc_tot;
        logic [33:0] prod;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 5; i++) begin
                    acc_row = '0;
                    for (int j = 0; j < 5; j++) begin
                        acc_row = acc_row + 15'(GAUSS_WT[i][j])
                                  * 15'(r_swin[i][j][k*CH_BITS +: CH_BITS]);
                    end
                    r_rsum[k][i] <= acc_row;
                end
                acc_tot = '0;
                for (int i = 0; i < 5; i++) begin
                    acc_tot = acc_tot + 17'(r_rsum[k][i]);
                end
                r_sum[k] <= acc_tot;
                prod      = 34'(r_sum[k]) * 34'(DIV_K);
                r_v[k]   <= prod[DIV_SHIFT +: CH_BITS];
            end
        end
    end

    // green test: keep the smoothed pixel or drop it to zero
    always_comb begin
        kept = '0;
        if (r_tag[4].interior
                && (9'(r_v[1]) > 9'(r_v[0]) + 9'(r_margin))
                && (9'(r_v[1]) > 9'(r_v[2]) + 9'(r_margin))) begin
            kept = {r_v[2], r_v[1], r_v[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kept <= kept;
        end
    end

    // gradient window: shift in column gc of kept rows gr-2..gr
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_gwin[i][j] <= '0;
                end
            end
        end else if (adv && r_vld[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_gwin[i][0] <= r_gwin[i][1];
                r_gwin[i][1] <= r_gwin[i][2];
            end
            r_gwin[0][2] <= r_mq[r_tag[5].s0];
            r_gwin[1][2] <= r_mq[~r_tag[5].s0];
            r_gwin[2][2] <= r_kept;
        end
    end

    // Sobel per channel, then squares
    always_ff @(posedge i_clk) begin
        logic signed [10:0] tl, tm, tr, ml, mr, bl, bm, br;
        logic signed [21:0] px, py;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                tl = $signed({3'b0, r_gwin[0][0][k*CH_BITS +: CH_BITS]});
                tm = $signed({3'b0, r_gwin[0][1][k*CH_BITS +: CH_BITS]});
                tr = $signed({3'b0, r_gwin[0][2][k*CH_BITS +: CH_BITS]});
                ml = $signed({3'b0, r_gwin[1][0][k*CH_BITS +: CH_BITS]});
                mr = $signed({3'b0, r_gwin[1][2][k*CH_BITS +: CH_BITS]});
                bl = $signed({3'b0, r_gwin[2][0][k*CH_BITS +: CH_BITS]});
                bm = $signed({3'b0, r_gwin[2][1][k*CH_BITS +: CH_BITS]});
                br = $signed({3'b0, r_gwin[2][2][k*CH_BITS +: CH_BITS]});
                if (r_tag[6].rzero) begin
                    tr = '0;
                    mr = '0;
                    br = '0;
                end
                r_gx[k] <= (tr + br + (mr <<< 1)) - (tl + bl + (ml <<< 1));
                r_gy[k] <= (bl + br + (bm <<< 1)) - (tl + tr + (tm <<< 1));
                px = 22'(r_gx[k]) * 22'(r_gx[k]);
                py = 22'(r_gy[k]) * 22'(r_gy[k]);
                r_gx2[k] <= px[19:0];
                r_gy2[k] <= py[19:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        logic hit;
        if (adv) begin
            hit = !r_tag[NST-1].zero;
            for (int k = 0; k < 3; k++) begin
                hit = hit && ((22'(r_gx2[k]) + 22'(r_gy2[k])) > r_t2);
            end
            r_out.edge_res  <= hit;
            r_out.frame_end <= r_tag[NST-1].last;
        end
    end

endmodule

>>> sv/gmep_checker.sv
`timescale 1ns / 1ps

module gmep_checker
    import gmep_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in         i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_index,
    input logic [11:0] i_cfg_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input is taken whenever the result slot is free or draining
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow result slot");

    // a waiting input request holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input request changed while waiting");

    // a waiting register write holds its index and data
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && !o_cfg_ready |=> i_cfg_valid && $stable({i_cfg_index, i_cfg_data}))
        else $error("register write changed while waiting");

endmodule

bind green_mask_edge_pipeline gmep_checker u_gmep_checker (.*);
